### src/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// wsdf_pkg: shared types and constants for the WebSocket frame deframer
// Phase codes, result kinds, opcodes and the result record passed from the
// parser to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdf_pkg;

  // Parser phase within a frame
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,  // first header byte: fin and opcode
    PH_HDR1 = 3'd1,  // second header byte: mask bit and short length
    PH_EXT  = 3'd2,  // extended big-endian length
    PH_KEY  = 3'd3,  // masking key
    PH_PAY  = 3'd4   // payload
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Short length codes announcing an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Extended length byte counts and key length
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam int LEN_W = 64;
  localparam int KEY_W = 32;

  // One result beat
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       message_end;
    logic [3:0] frame_opcode;
    logic       close_request;
  } result_t;

  function automatic logic is_data_op(input logic [3:0] op);
    return (op == OP_CONT) || (op == OP_BIN);
  endfunction

  function automatic logic wants_close(input logic [3:0] op);
    return !((op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
             (op == OP_PING) || (op == OP_PONG));
  endfunction

endpackage

`default_nettype wire

### src/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer: receive-side WebSocket base frame parser
// Parses the received byte stream into frames, unmasks data payload and
// flags message ends and close requests.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    rx_byte
//   output    out        out_valid / out_ready  kind, data_byte, message_end,
//                                               frame_opcode, close_request
//
// One result beat per input beat. The byte is parsed in the cycle it is
// accepted and its result is held in the output register the next cycle.
// A new byte is taken every cycle while the output register is empty or
// being drained, so throughput is one byte per clock.
// Reset returns the parser to the first header byte and clears the close flag.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer
  import wsdf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      data_byte,
  output logic            message_end,
  output logic [3:0]      frame_opcode,
  output logic            close_request
);

  logic    step;
  result_t res;
  result_t res_q;
  logic    closing;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  wsdf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (rx_byte),
    .res     (res),
    .closing (closing)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign kind          = res_q.kind;
  assign data_byte     = res_q.data_byte;
  assign message_end   = res_q.message_end;
  assign frame_opcode  = res_q.frame_opcode;
  assign close_request = res_q.close_request;

`ifndef ASSERT_OFF
  // Data beats only come from binary or continuation frames
  a_data_op: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DATA |-> frame_opcode == OP_CONT || frame_opcode == OP_BIN)
    else $error("data beat from non-data frame");

  // Empty-frame end always closes a message
  a_empty_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EMPTY |-> message_end)
    else $error("empty frame end without message end");

  // Data byte is zero unless a payload byte is carried
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> data_byte == 8'h00)
    else $error("stray data byte");

  // A close request leaves the close flag set
  a_close_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && close_request |-> closing)
    else $error("close request without close flag");

  // Close request and message end never share a beat
  a_close_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && close_request |-> !message_end && kind == KIND_NONE)
    else $error("close request on a data beat");
`endif

endmodule

`default_nettype wire

### src/wsdf_parser.sv
// ----------------------------------------------------------------------------
// wsdf_parser: frame header parser, unmasking and frame bookkeeping
// Consumes one byte per step, updates the frame state and produces the
// result for that byte combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdf_parser
  import wsdf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output result_t         res,
  output logic            closing
);

  phase_t             phase, phase_next;
  logic [3:0]         hdr_left, hdr_left_next;
  logic               fin_flag, fin_flag_next;
  logic [3:0]         cur_op, cur_op_next;
  logic               mask_flag, mask_flag_next;
  logic [LEN_W-1:0]   pay_left, pay_left_next;  // length, then bytes still due
  logic [KEY_W-1:0]   mask_key, mask_key_next;
  logic [1:0]         pay_pos, pay_pos_next;    // payload index mod 4
  logic               closing_next;

  logic               ext_len;
  logic               length_done;
  logic               mask_now;
  logic               key_done;
  logic               header_end;
  logic [LEN_W-1:0]   new_len;
  logic [LEN_W-1:0]   len_at_end;
  logic               frame_end;
  logic [7:0]         key_byte;

  // Shared decode of header and frame boundaries
  assign ext_len     = (rx_byte[6:0] == LEN_EXT16) || (rx_byte[6:0] == LEN_EXT64);
  assign new_len     = (phase == PH_HDR1) ? {{(LEN_W-7){1'b0}}, rx_byte[6:0]}
                                          : {pay_left[LEN_W-9:0], rx_byte};
  assign length_done = ((phase == PH_HDR1) && !ext_len) ||
                       ((phase == PH_EXT) && (hdr_left == 4'd1));
  assign mask_now    = (phase == PH_HDR1) ? rx_byte[7] : mask_flag;
  assign key_done    = (phase == PH_KEY) && (hdr_left == 4'd1);
  assign header_end  = (length_done && !mask_now) || key_done;
  assign len_at_end  = key_done ? pay_left : new_len;
  assign frame_end   = (header_end && (len_at_end == '0)) ||
                       ((phase == PH_PAY) && (pay_left == {{(LEN_W-1){1'b0}}, 1'b1}));

  // Phase sequencing
  always_comb begin
    phase_next = phase;
    priority if (phase != PH_HDR1 && phase != PH_EXT &&
                 phase != PH_KEY && phase != PH_PAY) begin
      phase_next = PH_HDR1;
    end else if (frame_end) begin
      phase_next = PH_HDR0;
    end else if (header_end) begin
      phase_next = PH_PAY;
    end else if (length_done) begin
      phase_next = PH_KEY;
    end else if (phase == PH_HDR1) begin
      phase_next = PH_EXT;
    end
  end

  // Frame state and result for this byte
  always_comb begin
    hdr_left_next  = hdr_left;
    fin_flag_next  = fin_flag;
    cur_op_next    = cur_op;
    mask_flag_next = mask_flag;
    pay_left_next  = pay_left;
    mask_key_next  = mask_key;
    pay_pos_next   = pay_pos;
    closing_next   = closing;
    key_byte       = mask_key[8*(3-pay_pos) +: 8];

    res.kind          = KIND_NONE;
    res.data_byte     = 8'h00;
    res.message_end   = 1'b0;
    res.frame_opcode  = cur_op;
    res.close_request = 1'b0;

    unique case (phase)
      PH_HDR1: begin
        mask_flag_next = rx_byte[7];
        mask_key_next  = '0;
        if (rx_byte[6:0] == LEN_EXT16) begin
          pay_left_next = '0;
          hdr_left_next = EXT16_BYTES;
        end else if (rx_byte[6:0] == LEN_EXT64) begin
          pay_left_next = '0;
          hdr_left_next = EXT64_BYTES;
        end else begin
          pay_left_next = new_len;
        end
      end
      PH_EXT: begin
        pay_left_next = new_len;
        hdr_left_next = hdr_left - 4'd1;
      end
      PH_KEY: begin
        mask_key_next = {mask_key[KEY_W-9:0], rx_byte};
        hdr_left_next = hdr_left - 4'd1;
      end
      PH_PAY: begin
        if (is_data_op(cur_op)) begin
          res.kind      = KIND_DATA;
          res.data_byte = rx_byte ^ key_byte;
        end
        pay_left_next = pay_left - {{(LEN_W-1){1'b0}}, 1'b1};
        pay_pos_next  = pay_pos + 2'd1;
      end
      default: begin
        fin_flag_next    = rx_byte[7];
        cur_op_next      = rx_byte[3:0];
        res.frame_opcode = rx_byte[3:0];
      end
    endcase

    // Length field complete with a key to follow
    if (length_done && mask_now) begin
      hdr_left_next = KEY_BYTES;
    end

    // Header complete: payload index restarts
    if (header_end) begin
      hdr_left_next = 4'd0;
      pay_pos_next  = 2'd0;
    end

    // Frame completion: message end or close request
    if (frame_end) begin
      if (is_data_op(cur_op)) begin
        if (fin_flag) begin
          if (res.kind == KIND_NONE) begin
            res.kind = KIND_EMPTY;
          end
          res.message_end = 1'b1;
        end
      end else if (wants_close(cur_op) && !closing) begin
        res.close_request = 1'b1;
        closing_next      = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HDR0;
      hdr_left <= 4'd0;
      closing  <= 1'b0;
    end else if (step) begin
      phase    <= phase_next;
      hdr_left <= hdr_left_next;
      closing  <= closing_next;
    end
  end

  // Frame fields
  always_ff @(posedge clk) begin
    if (step) begin
      fin_flag  <= fin_flag_next;
      cur_op    <= cur_op_next;
      mask_flag <= mask_flag_next;
      pay_left  <= pay_left_next;
      mask_key  <= mask_key_next;
      pay_pos   <= pay_pos_next;
    end
  end

endmodule

`default_nettype wire

### verif/tb_websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer: self-checking bench for the frame deframer
// Feeds WebSocket frames byte by byte through the valid/ready input and
// checks every result beat against a local parser model that is updated as
// each byte is taken. Directed frames cover the header forms, masking, empty
// and control frames and close handling. Random traffic, including broken
// framing, runs under three idling patterns, with one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_websocket_frame_deframer;
  import wsdf_pkg::*;

  localparam logic [3:0] OP_CLOSE     = 4'h8;
  localparam logic [3:0] OP_RSVD_CTRL = 4'hF;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         MAX_REPORTS  = 10;

  typedef enum logic [1:0] {FORM_SHORT, FORM_16, FORM_64} len_form_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       message_end;
  logic [3:0] frame_opcode;
  logic       close_request;

  // Parser model state
  phase_t      parse_phase;
  logic [3:0]  hdr_left;
  logic        fin_bit;
  logic [3:0]  cur_op;
  logic        masked;
  logic [63:0] frame_len;
  logic [31:0] key_word;
  logic [63:0] pay_pos;
  logic        close_sent;
  result_t     beat_exp;

  result_t     due_beats[$];
  result_t     seen_beat;
  result_t     want_beat;

  int          mismatches    = 0;
  int          cycle_count   = 0;
  int          hold_cycles   = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned bytes_sent    = 0;
  bit          cap_lengths   = 1'b0;

  websocket_frame_deframer uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .data_byte     (data_byte),
    .message_end   (message_end),
    .frame_opcode  (frame_opcode),
    .close_request (close_request)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("websocket_frame_deframer regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  function automatic logic carries_data(input logic [3:0] op);
    case (op)
      OP_CONT, OP_BIN: return 1'b1;
      default:         return 1'b0;
    endcase
  endfunction

  // Frame completes on the current byte
  function automatic void frame_complete();
    if (carries_data(cur_op)) begin
      if (fin_bit) begin
        if (beat_exp.kind == KIND_NONE) beat_exp.kind = KIND_EMPTY;
        beat_exp.message_end = 1'b1;
      end
    end else begin
      case (cur_op)
        OP_TEXT, OP_PING, OP_PONG: ;
        default: begin
          if (!close_sent) begin
            beat_exp.close_request = 1'b1;
            close_sent = 1'b1;
          end
        end
      endcase
    end
    parse_phase = PH_HDR0;
  endfunction

  function automatic void end_of_header();
    hdr_left = '0;
    pay_pos  = '0;
    if (frame_len == '0) frame_complete();
    else parse_phase = PH_PAY;
  endfunction

  function automatic void end_of_length();
    if (masked) begin
      parse_phase = PH_KEY;
      hdr_left = KEY_BYTES;
    end else begin
      end_of_header();
    end
  endfunction

  // Advance the model by one accepted byte and queue the beat it yields
  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] key_byte;
    beat_exp = '0;
    case (parse_phase)
      PH_HDR1: begin
        masked = b[7];
        key_word = '0;
        if (b[6:0] == LEN_EXT16) begin
          frame_len = '0;
          parse_phase = PH_EXT;
          hdr_left = EXT16_BYTES;
        end else if (b[6:0] == LEN_EXT64) begin
          frame_len = '0;
          parse_phase = PH_EXT;
          hdr_left = EXT64_BYTES;
        end else begin
          frame_len = {57'd0, b[6:0]};
          end_of_length();
        end
      end
      PH_EXT: begin
        frame_len = {frame_len[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == '0) end_of_length();
      end
      PH_KEY: begin
        key_word = {key_word[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == '0) end_of_header();
      end
      PH_PAY: begin
        key_byte = key_word[8 * (3 - pay_pos[1:0]) +: 8];
        if (carries_data(cur_op)) begin
          beat_exp.kind = KIND_DATA;
          beat_exp.data_byte = b ^ key_byte;
        end
        pay_pos = pay_pos + 64'd1;
        if (pay_pos == frame_len) frame_complete();
      end
      default: begin
        fin_bit = b[7];
        cur_op = b[3:0];
        parse_phase = PH_HDR1;
      end
    endcase
    beat_exp.frame_opcode = cur_op;
    due_beats = {due_beats, beat_exp};
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready pattern and beat checker
  // ---------------------------------------------------------------------------

  // Receiver ready, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_beat.kind          = kind;
      seen_beat.data_byte     = data_byte;
      seen_beat.message_end   = message_end;
      seen_beat.frame_opcode  = frame_opcode;
      seen_beat.close_request = close_request;
      if (due_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected beat: kind=%0d data=%02h end=%0b op=%0h close=%0b",
                   kind, data_byte, message_end, frame_opcode, close_request);
      end else begin
        want_beat = due_beats.pop_front();
        if (seen_beat.kind !== want_beat.kind ||
            seen_beat.data_byte !== want_beat.data_byte ||
            seen_beat.message_end !== want_beat.message_end ||
            seen_beat.frame_opcode !== want_beat.frame_opcode ||
            seen_beat.close_request !== want_beat.close_request) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: exp kind=%0d data=%02h end=%0b op=%0h close=%0b",
                     want_beat.kind, want_beat.data_byte, want_beat.message_end,
                     want_beat.frame_opcode, want_beat.close_request);
            $display("          got kind=%0d data=%02h end=%0b op=%0h close=%0b",
                     kind, data_byte, message_end, frame_opcode, close_request);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one byte; returns on the falling edge after it is taken
  task automatic send_byte(input logic [7:0] b_in);
    logic [7:0] b;
    b = b_in;
    // keep extended lengths small so random traffic cannot lock into a huge payload
    if (cap_lengths && parse_phase == PH_EXT && hdr_left > 4'd1)
      b = (hdr_left == 4'd2) ? (b & 8'h01) : 8'h00;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_header(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                             input logic mask_on, input logic [63:0] len,
                             input len_form_t form, input logic [31:0] key);
    send_byte({fin, rsv, op});
    case (form)
      FORM_SHORT: send_byte({mask_on, len[6:0]});
      FORM_16: begin
        send_byte({mask_on, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({mask_on, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    if (mask_on)
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
  endtask

  // Mostly well-formed frames with random content, some stray bytes
  task automatic random_frames(input int unsigned n_bytes);
    int unsigned start;
    int unsigned len;
    int          r;
    logic [3:0]  op;
    len_form_t   form;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35)      op = OP_BIN;
        else if (r < 55) op = OP_CONT;
        else if (r < 67) op = OP_TEXT;
        else if (r < 75) op = OP_PING;
        else if (r < 83) op = OP_PONG;
        else if (r < 90) op = OP_CLOSE;
        else             op = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 20)      len = 0;
        else if (r < 75) len = $urandom_range(1, 12);
        else if (r < 90) len = $urandom_range(13, 40);
        else if (r < 97) len = $urandom_range(100, 125);
        else             len = $urandom_range(126, 300);
        r = $urandom_range(0, 99);
        if (len > 125) form = (r < 50) ? FORM_16 : FORM_64;
        else if (r < 75) form = FORM_SHORT;
        else if (r < 90) form = FORM_16;
        else form = FORM_64;
        send_header(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), op,
                    1'($urandom_range(0, 1)), 64'(len), form, $urandom);
        repeat (len) send_byte(8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Data frames: unmasked extremes, masked with reserved bits, continuation end
  task automatic test_data_frames();
    send_header(1'b1, 3'b000, OP_BIN, 1'b0, 64'd2, FORM_SHORT, 32'h0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(1'b0, 3'b111, OP_BIN, 1'b1, 64'd2, FORM_SHORT, 32'hA55A_0FF0);
    send_byte(8'hFF);
    send_byte(8'h3C);
    send_header(1'b1, 3'b000, OP_CONT, 1'b0, 64'd1, FORM_SHORT, 32'h0);
    send_byte(8'h81);
  endtask

  // Empty frames: fin-marked gives an end marker, non-fin gives nothing
  task automatic test_empty_frames();
    send_header(1'b1, 3'b000, OP_CONT, 1'b1, 64'd0, FORM_SHORT, 32'hFFFF_FFFF);
    send_header(1'b0, 3'b000, OP_BIN, 1'b0, 64'd0, FORM_SHORT, 32'h0);
  endtask

  // Text, ping and pong payloads are dropped
  task automatic test_control_frames();
    send_header(1'b1, 3'b000, OP_TEXT, 1'b0, 64'd1, FORM_SHORT, 32'h0);
    send_byte(8'h41);
    send_header(1'b1, 3'b000, OP_PING, 1'b0, 64'd0, FORM_SHORT, 32'h0);
    send_header(1'b1, 3'b000, OP_PONG, 1'b0, 64'd1, FORM_SHORT, 32'h0);
    send_byte(8'h7E);
  endtask

  task automatic test_extended_lengths();
    send_header(1'b1, 3'b000, OP_BIN, 1'b0, 64'd1, FORM_16, 32'h0);
    send_byte(8'h5A);
    // empty frame finishing on the last length byte
    send_header(1'b1, 3'b000, OP_BIN, 1'b0, 64'd0, FORM_64, 32'h0);
  endtask

  // Close raised once; later close or undefined opcode frames stay quiet
  task automatic test_close_requests();
    send_header(1'b1, 3'b000, OP_CLOSE, 1'b0, 64'd0, FORM_SHORT, 32'h0);
    send_header(1'b1, 3'b000, OP_RSVD_CTRL, 1'b0, 64'd0, FORM_SHORT, 32'h0);
    send_header(1'b1, 3'b000, OP_CLOSE, 1'b0, 64'd0, FORM_SHORT, 32'h0);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    cap_lengths = 1'b1;
    random_frames(250);
  endtask

  // Long receiver hold-off while bytes keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 150;
    random_frames(60);
  endtask

  // 64-bit length with its top bit set; the frame never ends, so this runs last
  task automatic test_huge_length();
    cap_lengths = 1'b1;
    while (parse_phase != PH_HDR0) send_byte(8'($urandom));
    cap_lengths = 1'b0;
    send_header(1'b1, 3'b000, OP_BIN, 1'b1, 64'h8000_0000_0000_0003, FORM_64, $urandom);
    repeat (12) send_byte(8'($urandom));
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    rx_byte   = 8'h00;
    out_ready = 1'b0;

    parse_phase = PH_HDR0;
    hdr_left    = '0;
    fin_bit     = 1'b0;
    cur_op      = '0;
    masked      = 1'b0;
    frame_len   = '0;
    key_word    = '0;
    pay_pos     = '0;
    close_sent  = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_data_frames();
    test_empty_frames();
    test_control_frames();
    test_extended_lengths();
    test_close_requests();
    test_random_traffic(21, 65);
    test_random_traffic(65, 21);
    test_random_traffic(0, 0);
    test_backpressure();
    test_huge_length();

    // drain outstanding beats, then allow the output register to settle
    in_valid = 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0)
      $display("websocket_frame_deframer regression: pass");
    else
      $display("websocket_frame_deframer regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
src/wsdf_pkg.sv
src/wsdf_parser.sv
src/websocket_frame_deframer.sv
verif/tb_websocket_frame_deframer.sv
